// ===== hdl/wpbe_pkg.sv =====
`default_nettype none

package wpbe_pkg;

    // Item kinds carried in the mode field.
    localparam logic [1:0] MODE_SET_COLOR   = 2'd0;
    localparam logic [1:0] MODE_START_BLINK = 2'd1;
    localparam logic [1:0] MODE_TICK        = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_INTERVAL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PAIRS    = 1'b1;

    localparam logic [15:0] INTERVAL_RESET = 16'd500;
    localparam logic [7:0]  PAIRS_RESET    = 8'd3;

    // Symbol timing in 100 ns ticks.
    localparam logic [3:0] TICKS_LONG  = 4'd8;
    localparam logic [3:0] TICKS_SHORT = 4'd4;

    localparam int         FRAME_SYMBOLS = 24;
    localparam int         SYM_IDX_W     = 5;
    localparam logic [SYM_IDX_W-1:0] LAST_SYMBOL = SYM_IDX_W'(FRAME_SYMBOLS - 1);

    // Frame queue between the front and the serializer.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [3:0] high_ticks;
        logic [3:0] low_ticks;
        logic       data_bit;
        logic       last_of_frame;
        logic       blinking_now;
    } out_item_t;

    // One frame to send: color word in G, R, B order plus the blink flag.
    typedef struct packed {
        logic [23:0] grb;
        logic        blinking;
    } frame_cmd_t;

    // Up to two frames pushed by one item; the second only with the first.
    typedef struct packed {
        logic       push0;
        logic       push1;
        frame_cmd_t cmd0;
        frame_cmd_t cmd1;
    } frame_push_t;

    typedef struct packed {
        logic              not_empty;
        logic              room2;
        logic [QCNT_W-1:0] level;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== hdl/wpbe_front.sv =====
`default_nettype none

module wpbe_front #(
    parameter int INTERVAL_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [wpbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [wpbe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               item_accept,
    input  wire wpbe_pkg::in_item_t                 item,
    output wpbe_pkg::frame_push_t                   push
);
    import wpbe_pkg::*;

    logic [15:0]              interval_reg;
    logic [7:0]               pairs_reg;
    logic                     active_reg, active_next;
    logic                     lit_reg, lit_next;
    logic [8:0]               tally_reg, tally_next;
    logic [INTERVAL_BITS-1:0] elapsed_reg, elapsed_next;
    logic [7:0]               red_reg, red_next;
    logic [7:0]               green_reg, green_next;
    logic [7:0]               blue_reg, blue_next;

    logic [INTERVAL_BITS+15:0] interval_wide;
    logic [INTERVAL_BITS-1:0]  limit;
    logic [INTERVAL_BITS-1:0]  elapsed_inc;
    logic [8:0]                tally_inc;
    logic                      tick;
    logic                      hit;
    logic                      done;
    logic                      lit_toggled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            pairs_reg    <= PAIRS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLINK_INTERVAL: interval_reg <= cfg_data;
                REG_BLINK_PAIRS:    pairs_reg    <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // The 16-bit interval register is zero-extended or truncated to the timer width.
    assign interval_wide = {{INTERVAL_BITS{1'b0}}, interval_reg};
    assign limit         = interval_wide[INTERVAL_BITS-1:0];

    assign elapsed_inc = (elapsed_reg != {INTERVAL_BITS{1'b1}})
                         ? elapsed_reg + 1'b1 : elapsed_reg;
    assign tally_inc   = tally_reg + 9'd1;
    assign tick        = (item.mode == MODE_TICK) && active_reg;
    assign hit         = tick && (elapsed_inc >= limit);
    assign lit_toggled = !lit_reg;
    assign done        = hit && (tally_inc >= {pairs_reg, 1'b0});

    always_comb
    begin
        active_next  = active_reg;
        lit_next     = lit_reg;
        tally_next   = tally_reg;
        elapsed_next = elapsed_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        push         = '0;

        if (item_accept)
        begin
            priority if (item.mode == MODE_SET_COLOR)
            begin
                push.push0         = 1'b1;
                push.cmd0.grb      = {item.green, item.red, item.blue};
                push.cmd0.blinking = active_reg;
            end
            else if (item.mode == MODE_START_BLINK)
            begin
                tally_next   = '0;
                active_next  = 1'b1;
                lit_next     = 1'b0;
                red_next     = item.red;
                green_next   = item.green;
                blue_next    = item.blue;
                elapsed_next = '0;
            end
            else if (tick)
            begin
                elapsed_next = hit ? '0 : elapsed_inc;
                if (hit)
                begin
                    lit_next           = lit_toggled;
                    tally_next         = tally_inc;
                    active_next        = !done;
                    push.push0         = 1'b1;
                    push.cmd0.grb      = lit_toggled ? {green_reg, red_reg, blue_reg} : 24'd0;
                    push.cmd0.blinking = !done;
                    // The run ends with one more dark frame.
                    push.push1         = done;
                    push.cmd1.grb      = 24'd0;
                    push.cmd1.blinking = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            lit_reg     <= 1'b0;
            tally_reg   <= '0;
            elapsed_reg <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            lit_reg     <= lit_next;
            tally_reg   <= tally_next;
            elapsed_reg <= elapsed_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wpbe_queue.sv =====
`default_nettype none

module wpbe_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire wpbe_pkg::frame_push_t   push,
    input  wire logic                    pop,
    output wpbe_pkg::frame_cmd_t         head,
    output wpbe_pkg::queue_status_t      status
);
    import wpbe_pkg::*;

    frame_cmd_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic [1:0]        push_count;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign push_count   = {1'b0, push.push0} + {1'b0, push.push1};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
            entry_reg[wr_ptr_reg] <= push.cmd0;
        if (push.push1)
            entry_reg[wr_ptr_plus1] <= push.cmd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.room2     = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign status.level     = count_reg;

endmodule

`default_nettype wire

// ===== hdl/wpbe_serializer.sv =====
`default_nettype none

module wpbe_serializer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wpbe_pkg::frame_cmd_t  head,
    input  wire logic                  head_valid,
    output logic                       pop,
    output logic                       symbol_valid,
    input  wire logic                  symbol_stall,
    output wpbe_pkg::out_item_t        symbol
);
    import wpbe_pkg::*;

    logic                 busy_reg, busy_next;
    logic [23:0]          word_reg, word_next;
    logic                 blink_reg, blink_next;
    logic [SYM_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    logic      slot_free;
    logic      advance;
    logic      at_last;
    out_item_t current;

    assign slot_free = !out_valid_reg || !symbol_stall;
    assign advance   = slot_free && busy_reg;
    assign at_last   = (idx_reg == LAST_SYMBOL);
    // The next frame is taken on the cycle the last symbol leaves, so frames run back to back.
    assign pop       = head_valid && (!busy_reg || (advance && at_last));

    always_comb
    begin
        current.data_bit      = word_reg[23];
        current.high_ticks    = word_reg[23] ? TICKS_LONG : TICKS_SHORT;
        current.low_ticks     = word_reg[23] ? TICKS_SHORT : TICKS_LONG;
        current.last_of_frame = at_last;
        current.blinking_now  = blink_reg;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        word_next      = word_reg;
        blink_next     = blink_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (slot_free)
        begin
            out_valid_next = busy_reg;
            out_data_next  = current;
        end

        priority if (pop)
        begin
            busy_next  = 1'b1;
            word_next  = head.grb;
            blink_next = head.blinking;
            idx_next   = '0;
        end
        else if (advance)
        begin
            busy_next = !at_last;
            word_next = {word_reg[22:0], 1'b0};
            idx_next  = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        blink_reg    <= blink_next;
        out_data_reg <= out_data_next;
    end

    assign symbol_valid = out_valid_reg;
    assign symbol       = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/ws2812_pixel_blink_encoder_top.sv =====
// Single-pixel WS2812 encoder with a blinker. Each item sets a color (one 24-symbol frame,
// G, R, B, most significant bit first), starts a blink run (no symbols), or is a millisecond
// tick that may toggle the lamp and send a frame, plus a closing dark frame at the end of a
// run; an item of the unused mode does nothing. Items are accepted one per cycle while the
// four-entry frame queue has room for two frames; the serializer then sends one symbol per
// cycle while the output is not stalled, with no gap between frames. Symbols leave through
// an output register, so a stalled output does not block new items until three frames wait
// in the queue. Configuration writes take effect on the next item.
`default_nettype none

module ws2812_pixel_blink_encoder_top #(
    parameter int INTERVAL_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [wpbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [wpbe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire wpbe_pkg::in_item_t                 item,
    output logic                                    symbol_valid,
    input  wire logic                               symbol_stall,
    output wpbe_pkg::out_item_t                     symbol
);
    import wpbe_pkg::*;

    frame_push_t   push;
    frame_cmd_t    head;
    queue_status_t q_status;
    logic          pop;
    logic          item_accept;

    assign item_stall  = !q_status.room2;
    assign item_accept = item_valid && !item_stall;

    wpbe_front #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (item_accept),
        .item        (item),
        .push        (push)
    );

    wpbe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    wpbe_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (q_status.not_empty),
        .pop          (pop),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol       (symbol)
    );

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= QCNT_W'(QDEPTH))
        else $error("frame queue holds more than its depth");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.level == QCNT_W'(QDEPTH)) |-> item_stall)
        else $error("item taken while frame queue is full");

    a_symbol_code: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid |-> ((symbol.data_bit && symbol.high_ticks == TICKS_LONG
                           && symbol.low_ticks == TICKS_SHORT)
                       || (!symbol.data_bit && symbol.high_ticks == TICKS_SHORT
                           && symbol.low_ticks == TICKS_LONG)))
        else $error("symbol timing does not match its bit");
`endif

endmodule

`default_nettype wire

// ===== verif/ws2812_pixel_blink_encoder_top_tb.sv =====
module ws2812_pixel_blink_encoder_top_tb;
    import wpbe_pkg::*;

    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [15:0] INTERVAL_MAX  = 16'hFFFF;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          RANDOM_ITEMS  = 150;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    in_item_t               item         = '0;
    logic                   symbol_valid;
    logic                   symbol_stall = 1'b0;
    out_item_t              symbol;

    in_item_t  pixel_items[$];
    out_item_t symbols_due[$];
    int        errors     = 0;
    bit        steady     = 1'b0;
    int        send_gap   = 0;
    int        stall_left = 0;

    // Shadow of the pixel controller: registers and blinker state.
    logic [15:0] interval_reg  = INTERVAL_RESET;
    logic [7:0]  pairs_reg     = PAIRS_RESET;
    logic        lamp_blinking = 1'b0;
    logic        lamp_lit      = 1'b0;
    logic [8:0]  toggle_count  = '0;
    logic [15:0] ms_elapsed    = '0;
    logic [7:0]  held_red      = '0;
    logic [7:0]  held_green    = '0;
    logic [7:0]  held_blue     = '0;

    ws2812_pixel_blink_encoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol       (symbol)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    // Steps the shadow controller by one item and queues the symbols it sends.
    task automatic encode_item(input in_item_t it);
        logic [23:0] frames [2];
        int          nframes;
        out_item_t   sym;
        nframes = 0;
        case (it.mode)
            MODE_SET_COLOR:
            begin
                frames[0] = {it.green, it.red, it.blue};
                nframes   = 1;
            end
            MODE_START_BLINK:
            begin
                toggle_count  = '0;
                lamp_blinking = 1'b1;
                lamp_lit      = 1'b0;
                held_red      = it.red;
                held_green    = it.green;
                held_blue     = it.blue;
                ms_elapsed    = '0;
            end
            MODE_TICK:
            begin
                if (lamp_blinking)
                begin
                    if (ms_elapsed != INTERVAL_MAX)
                        ms_elapsed++;
                    if (ms_elapsed >= interval_reg)
                    begin
                        ms_elapsed = '0;
                        lamp_lit   = !lamp_lit;
                        frames[0]  = lamp_lit ? {held_green, held_red, held_blue} : 24'd0;
                        nframes    = 1;
                        toggle_count++;
                        if (toggle_count >= {pairs_reg, 1'b0})
                        begin
                            lamp_blinking = 1'b0;
                            frames[1]     = 24'd0;
                            nframes       = 2;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int f = 0; f < nframes; f++)
        begin
            for (int s = 0; s < FRAME_SYMBOLS; s++)
            begin
                sym.data_bit      = frames[f][FRAME_SYMBOLS - 1 - s];
                sym.high_ticks    = sym.data_bit ? TICKS_LONG : TICKS_SHORT;
                sym.low_ticks     = sym.data_bit ? TICKS_SHORT : TICKS_LONG;
                sym.last_of_frame = (s == FRAME_SYMBOLS - 1);
                sym.blinking_now  = lamp_blinking;
                symbols_due.push_back(sym);
            end
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Item sender: presents the head of the pending list, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            send_gap   = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                encode_item(item);
                void'(pixel_items.pop_front());
            end
            if (item_valid && item_stall)
            begin
                // Hold the stalled item as it is.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pixel_items.size() != 0)
            begin
                item_valid <= 1'b1;
                item       <= pixel_items[0];
                send_gap   = gap_len();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Symbol receiver: checks each accepted symbol and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin : symbol_check
        out_item_t want;
        if (!rst_n)
        begin
            symbol_stall <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (symbol_valid && !symbol_stall)
            begin
                if (symbols_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected symbol, expected none, actual %h", $time, symbol);
                end
                else
                begin
                    want = symbols_due.pop_front();
                    check_field("high_ticks", want.high_ticks, symbol.high_ticks);
                    check_field("low_ticks", want.low_ticks, symbol.low_ticks);
                    check_field("data_bit", want.data_bit, symbol.data_bit);
                    check_field("last_of_frame", want.last_of_frame, symbol.last_of_frame);
                    check_field("blinking_now", want.blinking_now, symbol.blinking_now);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                symbol_stall <= 1'b1;
            end
            else
            begin
                symbol_stall <= 1'b0;
                stall_left   = gap_len();
            end
        end
    end

    function automatic void add_item(input logic [1:0] mode, input logic [7:0] r,
                                     input logic [7:0] g, input logic [7:0] b);
        in_item_t it;
        it.mode  = mode;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        pixel_items.push_back(it);
    endfunction

    function automatic void add_ticks(input int count);
        for (int i = 0; i < count; i++)
            add_item(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Waits until every item is taken and every symbol has come, then lets
    // items that send nothing finish inside the block.
    task automatic wait_idle();
        while (pixel_items.size() != 0 || item_valid || symbols_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] interval_ms, input logic [7:0] pairs);
        cfg_write <= 1'b1;
        cfg_index <= REG_BLINK_INTERVAL;
        cfg_data  <= interval_ms;
        @(posedge clk);
        cfg_index <= REG_BLINK_PAIRS;
        cfg_data  <= CFG_DATA_W'(pairs);
        @(posedge clk);
        cfg_write    <= 1'b0;
        interval_reg = interval_ms;
        pairs_reg    = pairs;
    endtask

    initial
    begin : stimulus
        int          made;
        int          run_ticks;
        int          pick;
        logic [15:0] interval_ms;
        logic [7:0]  pairs;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with the registers at their reset values.
        add_item(MODE_SET_COLOR, 8'h00, 8'h00, 8'h00);
        add_item(MODE_SET_COLOR, 8'hFF, 8'hFF, 8'hFF);
        add_item(MODE_SET_COLOR, 8'hA5, 8'h5A, 8'hC3);
        add_item(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        add_item(MODE_TICK, 8'h00, 8'hFF, 8'h00);
        add_item(MODE_START_BLINK, 8'h12, 8'h34, 8'h56);
        add_ticks(40);
        // A restart in the middle of a run begins the run again.
        add_item(MODE_START_BLINK, 8'hFF, 8'h00, 8'h80);
        add_ticks(20);
        add_item(MODE_SET_COLOR, 8'h0F, 8'hF0, 8'h3C);
        add_ticks(10);
        wait_idle();

        // With no pairs the first toggle ends the run at once.
        set_regs(16'd0, 8'd0);
        add_item(MODE_START_BLINK, 8'h81, 8'h42, 8'h24);
        add_ticks(2);
        wait_idle();

        set_regs(16'd1, 8'd1);
        add_item(MODE_START_BLINK, 8'h01, 8'h80, 8'h7E);
        add_ticks(1);
        add_item(MODE_START_BLINK, 8'h3C, 8'hC3, 8'h99);
        add_ticks(3);
        wait_idle();

        // Longest interval: the lamp stays dark for these few ticks.
        steady = 1'b1;
        set_regs(INTERVAL_MAX, 8'd1);
        add_item(MODE_START_BLINK, 8'hDE, 8'hAD, 8'hBE);
        add_ticks(4);
        wait_idle();

        // The run above is still armed and now follows the new registers.
        set_regs(16'd0, 8'd130);
        add_ticks(3);
        // This run needs more than 255 toggles before it ends.
        add_item(MODE_START_BLINK, 8'h55, 8'hAA, 8'h11);
        add_ticks(262);
        wait_idle();
        steady = 1'b0;

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                interval_ms = 16'($urandom_range(0, 6));
                pairs       = 8'($urandom_range(0, 5));
            end
            else
            begin
                interval_ms = 16'($urandom_range(20, 60));
                pairs       = 8'($urandom_range(0, 1));
            end
            steady = ($urandom_range(0, 3) == 0);
            set_regs(interval_ms, pairs);
            repeat (4)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    // A blink run, sometimes cut short by the next segment.
                    add_item(MODE_START_BLINK, 8'($urandom), 8'($urandom), 8'($urandom));
                    made++;
                    run_ticks = $urandom_range(1, (interval_ms == 0 ? 1 : int'(interval_ms))
                                                  * (2 * int'(pairs) + 1) + 2);
                    repeat (run_ticks)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            add_item(MODE_SET_COLOR, 8'($urandom), 8'($urandom),
                                     8'($urandom));
                        else
                            add_ticks(1);
                        made++;
                    end
                end
                else if (pick < 80)
                begin
                    add_item(MODE_SET_COLOR, 8'($urandom), 8'($urandom), 8'($urandom));
                    made++;
                end
                else if (pick < 90)
                    add_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
                else
                    add_ticks($urandom_range(1, 3));
            end
            wait_idle();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
